### hw/rtl/rbwd_pkg.sv
`timescale 1ns / 1ps

package rbwd_pkg;

  localparam int unsigned AddrWidth  = 32;
  localparam int unsigned IndexWidth = 27;
  localparam int unsigned MibShift   = 20;
  localparam int unsigned SizeWidth  = 8;
  localparam int unsigned SelWidth   = 2;
  localparam int unsigned BankWidth  = 7;   // bank sizes in MiB, at most 64
  localparam int unsigned LocWidth   = 6;   // bank B location in MiB, at most 32

  localparam logic [SizeWidth-1:0] MaxRamMib  = 8'd128;
  localparam logic [SizeWidth-1:0] SizeReset  = 8'd8;
  localparam logic [SelWidth-1:0]  SelReset   = 2'd0;
  localparam logic [BankWidth-1:0] BankAMaxMib = 7'd64;

  // apb register map, word index
  localparam logic RegRamSize = 1'b0;
  localparam logic RegBankSel = 1'b1;

  localparam logic [LocWidth-1:0] BankBLocMib [4] = '{6'd1, 6'd2, 6'd8, 6'd32};

  typedef struct packed {
    logic [SizeWidth-1:0] mib;
    logic [BankWidth-1:0] a_mib;
    logic [BankWidth-1:0] b_mib;
    logic                 no_mirror;
    logic                 mirror_b;
    logic [LocWidth-1:0]  loc_mib;
  } layout_t;

  function automatic layout_t rbwd_layout(logic [SizeWidth-1:0] size_raw,
                                          logic [SelWidth-1:0]  sel);
    layout_t              lay;
    logic [SizeWidth-1:0] mib;
    logic [SizeWidth-1:0] a_full;
    mib = size_raw;
    if (mib == '0) begin
      mib = 8'd1;
    end
    if (mib > MaxRamMib) begin
      mib = MaxRamMib;
    end
    a_full = (mib < {1'b0, BankAMaxMib}) ? mib : {1'b0, BankAMaxMib};
    lay.mib       = mib;
    lay.a_mib     = a_full[BankWidth-1:0];
    lay.b_mib     = BankWidth'(mib - a_full);
    lay.no_mirror = 1'b0;
    lay.mirror_b  = 1'b0;
    lay.loc_mib   = BankBLocMib[sel];
    case (mib)
      8'd1, 8'd16: lay.no_mirror = 1'b1;
      8'd2: begin
        lay.a_mib = 7'd1;  lay.b_mib = 7'd1;
      end
      8'd4: begin
        lay.no_mirror = 1'b1; lay.a_mib = 7'd4; lay.b_mib = 7'd0;
      end
      8'd5: begin
        lay.a_mib = 7'd4;  lay.b_mib = 7'd1;  lay.mirror_b = 1'b1;
      end
      8'd8: begin
        lay.a_mib = 7'd4;  lay.b_mib = 7'd4;
      end
      8'd17: begin
        lay.a_mib = 7'd16; lay.b_mib = 7'd1;  lay.mirror_b = 1'b1;
      end
      8'd20: begin
        lay.a_mib = 7'd16; lay.b_mib = 7'd4;  lay.mirror_b = 1'b1;
      end
      8'd65: begin
        lay.a_mib = 7'd64; lay.b_mib = 7'd1;  lay.mirror_b = 1'b1;
      end
      8'd68: begin
        lay.a_mib = 7'd64; lay.b_mib = 7'd4;  lay.mirror_b = 1'b1;
      end
      8'd80: begin
        lay.a_mib = 7'd64; lay.b_mib = 7'd16; lay.mirror_b = 1'b1;
      end
      8'd128: begin
        lay.a_mib = 7'd64; lay.b_mib = 7'd64;
      end
      default: ;
    endcase
    return lay;
  endfunction

endpackage

### hw/rtl/rbwd_decode.sv
`timescale 1ns / 1ps

module rbwd_decode import rbwd_pkg::*; (
  input  logic [AddrWidth-1:0]  addr_i,
  input  layout_t               lay_i,
  output logic                  hit_o,
  output logic [IndexWidth-1:0] index_o
);

  localparam int unsigned MibWidth = AddrWidth - MibShift;
  localparam int unsigned IdxMibW  = IndexWidth - MibShift;

  logic [MibWidth-1:0]  addr_mib;
  logic [IdxMibW-1:0]   addr_mib_lo;
  logic [SizeWidth:0]   mirror_lim;
  logic [SizeWidth:0]   reloc_floor;
  logic [SizeWidth:0]   reloc_end;
  logic [BankWidth-1:0] span;
  logic [IdxMibW-1:0]   mirror_base;
  logic [IdxMibW-1:0]   mirror_mib;
  logic [IdxMibW-1:0]   reloc_mib;
  logic                 probe_mode;
  logic                 direct_hit;
  logic                 mirror_hit;
  logic                 reloc_hit;

  assign addr_mib    = addr_i[AddrWidth-1:MibShift];
  assign addr_mib_lo = addr_i[IndexWidth-1:MibShift];

  assign span        = lay_i.mirror_b ? lay_i.b_mib : lay_i.a_mib;
  assign mirror_lim  = {1'b0, lay_i.mib} + (SizeWidth+1)'(span);
  assign reloc_floor = {1'b0, lay_i.mib} + (SizeWidth+1)'(lay_i.a_mib);
  assign reloc_end   = (SizeWidth+1)'(lay_i.loc_mib) + (SizeWidth+1)'(lay_i.b_mib);

  assign probe_mode = !lay_i.no_mirror && (SizeWidth'(lay_i.loc_mib) > lay_i.mib);
  assign direct_hit = addr_mib < MibWidth'(lay_i.mib);
  assign mirror_hit = !lay_i.no_mirror && (addr_mib < MibWidth'(mirror_lim));
  assign reloc_hit  = (lay_i.b_mib != '0)
                   && ((SizeWidth+1)'(lay_i.loc_mib) >= reloc_floor)
                   && (addr_mib >= MibWidth'(lay_i.loc_mib))
                   && (addr_mib < MibWidth'(reloc_end));

  // index arithmetic wraps at the storage size, so only the low MiB bits matter
  assign mirror_base = lay_i.mirror_b ? IdxMibW'(lay_i.a_mib) : '0;
  assign mirror_mib  = mirror_base + addr_mib_lo - lay_i.mib[IdxMibW-1:0];
  assign reloc_mib   = IdxMibW'(lay_i.a_mib) + addr_mib_lo - IdxMibW'(lay_i.loc_mib);

  always_comb begin
    hit_o   = 1'b0;
    index_o = '0;
    if (probe_mode) begin
      if (addr_mib == '0) begin
        hit_o   = 1'b1;
        index_o = addr_i[IndexWidth-1:0];
      end
    end else if (direct_hit) begin
      hit_o   = 1'b1;
      index_o = addr_i[IndexWidth-1:0];
    end else if (mirror_hit) begin
      hit_o   = 1'b1;
      index_o = {mirror_mib, addr_i[MibShift-1:0]};
    end else if (reloc_hit) begin
      hit_o   = 1'b1;
      index_o = {reloc_mib, addr_i[MibShift-1:0]};
    end
  end

endmodule

### hw/rtl/ram_bank_window_decoder_core.sv
`timescale 1ns / 1ps
// an item moves from the address register to the result register, which drives done_o
// throughput: one item per cycle, busy never rises
// results are shown for one cycle only; the receiver cannot stall
// reset: ram size 8 MiB, bank B window select 0, pipeline emptied
// the size table lookup and the window compares sit in one stage after the address register

module ram_bank_window_decoder_core import rbwd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // item in
  input  logic                  start,
  output logic                  busy,
  input  logic [AddrWidth-1:0]  phys_address_i,
  // item out
  output logic                  done_o,
  output logic                  ram_hit_o,
  output logic [IndexWidth-1:0] ram_byte_index_o,
  // apb configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic                  reg_idx;
  logic                  cfg_wr;
  logic [SizeWidth-1:0]  ram_size_q;
  logic [SelWidth-1:0]   win_sel_q;
  layout_t               layout;

  logic                  accept;
  logic                  in_valid_q;
  logic [AddrWidth-1:0]  addr_q;

  logic                  hit_d;
  logic [IndexWidth-1:0] index_d;
  logic                  done_q;
  logic                  hit_q;
  logic [IndexWidth-1:0] index_q;

  // ---------------------------------------------------------------------------
  // configuration registers, word addressed
  // ---------------------------------------------------------------------------
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_size_q <= SizeReset;
      win_sel_q  <= SelReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegRamSize: ram_size_q <= pwdata[SizeWidth-1:0];
        RegBankSel: win_sel_q  <= pwdata[SelWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegRamSize: prdata = {{(32-SizeWidth){1'b0}}, ram_size_q};
      RegBankSel: prdata = {{(32-SelWidth){1'b0}}, win_sel_q};
      default:    prdata = '0;
    endcase
  end

  // bank sizes and mirror flags come straight from the registers; the user must
  // change them only while no item is in flight; the block does not enforce this
  assign layout = rbwd_layout(ram_size_q, win_sel_q);

  // ---------------------------------------------------------------------------
  // stage 1: address register
  // ---------------------------------------------------------------------------
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= phys_address_i;
    end
  end

  // ---------------------------------------------------------------------------
  // decode: probe window, direct, mirror, relocated bank B window
  // ---------------------------------------------------------------------------
  rbwd_decode u_decode (
    .addr_i  (addr_q),
    .lay_i   (layout),
    .hit_o   (hit_d),
    .index_o (index_d)
  );

  // ---------------------------------------------------------------------------
  // stage 2: result register, shown for exactly one cycle
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      hit_q   <= hit_d;
      index_q <= index_d;
    end
  end

  assign done_o           = done_q;
  assign ram_hit_o        = hit_q;
  assign ram_byte_index_o = index_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_item_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q |=> done_o)
    else $error("decoded item did not reach the result stage");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(in_valid_q))
    else $error("result strobe without an item in the address stage");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ram_hit_o) |-> (ram_byte_index_o == '0))
    else $error("miss carries a nonzero byte index");

  a_direct_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !layout.no_mirror && (addr_q[AddrWidth-1:MibShift] == '0))
      |=> (ram_hit_o && (ram_byte_index_o == $past(addr_q[IndexWidth-1:0]))))
    else $error("first MiB did not map one to one");

endmodule

### tb/ram_bank_window_decoder_core_tb.sv
`timescale 1ns / 1ps

module ram_bank_window_decoder_core_tb;
  import rbwd_pkg::*;

  localparam longint unsigned MibBytes = 64'd1 << MibShift;
  localparam int unsigned TimeoutCycles = 100000;
  localparam int unsigned PhaseCount = 17;
  localparam int unsigned ItemsPerPhase = 50;

  // one decode outcome, compared field by field
  typedef struct packed {
    logic                  hit;
    logic [IndexWidth-1:0] index;
  } decode_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [AddrWidth-1:0]  phys_address_i = '0;
  logic                  done_o;
  logic                  ram_hit_o;
  logic [IndexWidth-1:0] ram_byte_index_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [2:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // shadow copy of the two registers, starts at the reset values
  logic [SizeWidth-1:0] size_setting = SizeReset;
  logic [SelWidth-1:0]  sel_setting = SelReset;

  decode_t     pending_decodes[$];
  int unsigned mismatch_count = 0;
  int unsigned decode_count = 0;
  int unsigned hit_count = 0;
  int unsigned layout_count = 1;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;

  ram_bank_window_decoder_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .phys_address_i  (phys_address_i),
    .done_o          (done_o),
    .ram_hit_o       (ram_hit_o),
    .ram_byte_index_o(ram_byte_index_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #5 clk_i = ~clk_i;

  // effective installed size in MiB: zero reads as one, large values clamp
  function automatic longint unsigned effective_mib(logic [SizeWidth-1:0] size_reg);
    longint unsigned mib;
    mib = 64'(size_reg);
    if (mib == 0) begin
      mib = 1;
    end
    if (mib > MaxRamMib) begin
      mib = 64'(MaxRamMib);
    end
    return mib;
  endfunction

  // expected decode of one address under a given register setting
  function automatic decode_t decode_address(logic [SizeWidth-1:0] size_reg,
                                             logic [SelWidth-1:0]  sel_reg,
                                             logic [AddrWidth-1:0] addr);
    longint unsigned mib, a_mib, b_mib, mem, bank_a, bank_b, loc, span, addr64, idx;
    bit              no_mirror, mirror_b;
    decode_t         res;
    mib = effective_mib(size_reg);
    // default split: bank A takes up to 64 MiB, bank B the rest
    a_mib = (mib < BankAMaxMib) ? mib : 64'(BankAMaxMib);
    b_mib = mib - a_mib;
    no_mirror = 1'b0;
    mirror_b = 1'b0;
    // the fixed size table overrides the split for known fits
    case (mib)
      1, 16: no_mirror = 1'b1;
      2: begin
        a_mib = 1;  b_mib = 1;
      end
      4: begin
        no_mirror = 1'b1; a_mib = 4; b_mib = 0;
      end
      5: begin
        a_mib = 4;  b_mib = 1;  mirror_b = 1'b1;
      end
      8: begin
        a_mib = 4;  b_mib = 4;
      end
      17: begin
        a_mib = 16; b_mib = 1;  mirror_b = 1'b1;
      end
      20: begin
        a_mib = 16; b_mib = 4;  mirror_b = 1'b1;
      end
      65: begin
        a_mib = 64; b_mib = 1;  mirror_b = 1'b1;
      end
      68: begin
        a_mib = 64; b_mib = 4;  mirror_b = 1'b1;
      end
      80: begin
        a_mib = 64; b_mib = 16; mirror_b = 1'b1;
      end
      128: begin
        a_mib = 64; b_mib = 64;
      end
      default: ;
    endcase
    mem = mib * MibBytes;
    bank_a = a_mib * MibBytes;
    bank_b = b_mib * MibBytes;
    loc = 64'(BankBLocMib[sel_reg]) * MibBytes;
    span = mirror_b ? bank_b : bank_a;
    addr64 = 64'(addr);
    res = '0;
    idx = 0;
    // first matching window wins
    if (!no_mirror && loc > mem) begin
      // probe window: bank B sits beyond the installed size
      if (addr64 < ((mem < MibBytes) ? mem : MibBytes)) begin
        res.hit = 1'b1; idx = addr64;
      end
    end else if (addr64 < mem) begin
      res.hit = 1'b1; idx = addr64;
    end else if (!no_mirror && addr64 < mem + span) begin
      res.hit = 1'b1; idx = (mirror_b ? bank_a : 0) + (addr64 - mem);
    end else if (bank_b > 0 && loc >= mem + bank_a && addr64 >= loc && addr64 < loc + bank_b)
    begin
      res.hit = 1'b1; idx = bank_a + (addr64 - loc);
    end
    if (res.hit) begin
      res.index = IndexWidth'(idx);
    end
    return res;
  endfunction

  // addresses near the window edges, with some wholly random ones
  function automatic logic [AddrWidth-1:0] pick_address(logic [SizeWidth-1:0] size_reg,
                                                        logic [SelWidth-1:0]  sel_reg);
    longint unsigned mem, base;
    int unsigned     span_mib;
    mem = effective_mib(size_reg) * MibBytes;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return AddrWidth'($urandom_range(0, 32'(2 * MibBytes)));
      default: begin
        case ($urandom_range(0, 4))
          0: base = MibBytes;
          1: base = 64'(BankBLocMib[sel_reg]) * MibBytes;
          2: base = mem;
          default: begin
            // ends of the mirror range for every bank size of the size table
            case ($urandom_range(0, 3))
              0: span_mib = 1;
              1: span_mib = 4;
              2: span_mib = 16;
              default: span_mib = 64;
            endcase
            base = mem + span_mib * MibBytes;
          end
        endcase
        if ($urandom_range(0, 1)) begin
          return AddrWidth'(base + $urandom_range(0, 8) - 4);
        end
        return AddrWidth'(base + $urandom_range(0, 32'(2 * MibBytes)) - MibBytes);
      end
    endcase
  endfunction

  // one item into the block; bursts of random length split by random gaps
  task automatic send_address(input logic [AddrWidth-1:0] addr);
    int unsigned gap;
    if (burst_left == 0) begin
      // some bursts follow straight on, no idle cycles at all
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    start <= 1'b1;
    phys_address_i <= addr;
    do @(posedge clk_i); while (busy);
    burst_left--;
  endtask

  // let every expected decode come back before touching the registers
  task automatic drain_decodes();
    start <= 1'b0;
    burst_left = 0;
    repeat (2) @(posedge clk_i);
    while (pending_decodes.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic write_register(input logic reg_code, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_code, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_code == RegRamSize) begin
      size_setting = value[SizeWidth-1:0];
    end else begin
      sel_setting = value[SelWidth-1:0];
    end
  endtask

  // new layout; upper data bits are random and must be ignored
  task automatic set_layout(input logic [SizeWidth-1:0] size_reg,
                            input logic [SelWidth-1:0]  sel_reg);
    drain_decodes();
    write_register(RegRamSize, {24'($urandom_range(0, 32'h00FF_FFFF)), size_reg});
    write_register(RegBankSel, {30'($urandom_range(0, 32'h3FFF_FFFF)), sel_reg});
    @(posedge clk_i);
    layout_count++;
  endtask

  // reset values: 8 MiB split 4/4, bank A mirrored above the installed size
  task automatic test_reset_layout();
    send_address('0);
    send_address(32'h007F_FFFF);
    send_address(32'h0080_0000);
    send_address(32'h00BF_FFFF);
    send_address(32'h00C0_0000);
    send_address(32'hFFFF_FFFF);
  endtask

  // probe window, zero and oversized sizes, mirror of A and of B, no-mirror edge
  task automatic test_directed_cases();
    set_layout(8'd2, 2'd3);
    send_address(32'h0000_0000);
    send_address(32'h000F_FFFF);
    send_address(32'h0010_0000);
    send_address(32'h0020_0000);
    set_layout(8'd0, 2'd0);
    send_address(32'h000F_FFFF);
    send_address(32'h0010_0000);
    set_layout(8'd255, 2'd3);
    send_address(32'h07FF_FFFF);
    send_address(32'h0800_0000);
    send_address(32'h0BFF_FFFF);
    send_address(32'h0C00_0000);
    set_layout(8'd80, 2'd0);
    send_address(32'h0500_0000);
    send_address(32'h05FF_FFFF);
    send_address(32'h0600_0000);
    set_layout(8'd16, 2'd3);
    send_address(32'h00FF_FFFF);
    send_address(32'h0200_0000);
  endtask

  // random layouts, each followed by a stream of edge-seeking addresses
  task automatic test_random_layouts();
    logic [SizeWidth-1:0] size_reg;
    logic [SizeWidth-1:0] table_sizes[12];
    logic [SizeWidth-1:0] extreme_sizes[6];
    table_sizes = '{8'd1, 8'd2, 8'd4, 8'd5, 8'd8, 8'd16, 8'd17, 8'd20,
                    8'd65, 8'd68, 8'd80, 8'd128};
    extreme_sizes = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd255};
    for (int phase = 0; phase < PhaseCount; phase++) begin
      case ($urandom_range(0, 4))
        0, 1: size_reg = table_sizes[$urandom_range(0, 11)];
        2: size_reg = extreme_sizes[$urandom_range(0, 5)];
        default: size_reg = SizeWidth'($urandom_range(0, 255));
      endcase
      set_layout(size_reg, SelWidth'($urandom_range(0, 3)));
      for (int n = 0; n < ItemsPerPhase; n++) begin
        send_address(pick_address(size_setting, sel_setting));
      end
    end
  endtask

  // result check first, then record the item taken at this edge
  always @(posedge clk_i) begin
    decode_t got, want;
    if (rst_ni) begin
      if (done_o) begin
        got.hit = ram_hit_o;
        got.index = ram_byte_index_o;
        if (pending_decodes.size() == 0) begin
          $display("%0t unexpected result: hit %0b index %h", $realtime, got.hit, got.index);
          mismatch_count++;
        end else begin
          want = pending_decodes.pop_front();
          decode_count++;
          if (got.hit) begin
            hit_count++;
          end
          if (got.hit !== want.hit) begin
            $display("%0t ram_hit mismatch: expected %0b actual %0b",
                     $realtime, want.hit, got.hit);
            mismatch_count++;
          end
          if (got.index !== want.index) begin
            $display("%0t ram_byte_index mismatch: expected %h actual %h",
                     $realtime, want.index, got.index);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        pending_decodes.push_back(decode_address(size_setting, sel_setting, phys_address_i));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= TimeoutCycles) begin
      $display("timeout after %0d cycles, %0d decodes outstanding",
               cycle_count, pending_decodes.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_layout();
    test_directed_cases();
    test_random_layouts();

    // drain, then keep idling past the pipeline depth
    drain_decodes();

    $display("checked %0d decodes (%0d hits) across %0d register layouts",
             decode_count, hit_count, layout_count);
    if (mismatch_count == 0 && pending_decodes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/rbwd_pkg.sv
hw/rtl/rbwd_decode.sv
hw/rtl/ram_bank_window_decoder_core.sv
tb/ram_bank_window_decoder_core_tb.sv
